>>> src/slbs_pkg.sv
// Shared constants, types and helpers for the status light blink sequencer.
`default_nettype none

package slbs_pkg;

  // Pattern steps per blink cycle and length of the failsafe flash
  localparam int unsigned STEPS_PER_CYCLE = 10;
  localparam int unsigned FLASH_LENGTH    = 10;

  // Register map (word index) and reset values
  localparam int unsigned  REG_TICKS_PER_STEP   = 0;
  localparam logic [3:0]   TICKS_PER_STEP_RESET = 4'd5;

  // GPS state codes
  localparam logic [1:0] GPS_NONE   = 2'd0;
  localparam logic [1:0] GPS_LOCKED = 2'd3;

  // Light register, one bit per light
  typedef struct packed {
    logic motor_b;
    logic motor_a;
    logic gps;
    logic arm;
  } light_t;

  // Blink pattern: on at steps 3, 4, 8 and 9
  function automatic logic blink_on(input logic [3:0] step);
    blink_on = (step == 4'd3) || (step == 4'd4) || (step == 4'd8) || (step == 4'd9);
  endfunction

endpackage

`default_nettype wire

>>> src/status_led_blink_sequencer.sv
// Status light blink sequencer: prescaler, step counter, light patterns and flash.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one base tick per request
//   with the status flags. Output channel (out_valid_o / out_stall_i) returns
//   one request per tick with the four light states after that tick.
//   A request is taken at a rising edge with valid high and stall low.
//   The result is registered: it is valid in the cycle after the tick is accepted.
//   Throughput: one tick per cycle unless stalled; the light register is the
//   output register, so a new tick is taken in the same cycle the pending
//   result is drained. When the receiver stalls with a result pending,
//   in_stall_o rises and the state holds until the result is taken.
//   Configuration: APB register ticks_per_step at byte address 0 (reset 5,
//   0 acts as 1). Write only while idle; pready is always high.
//   Reset (rst_ni low, asynchronous): counters cleared, no flash running,
//   all lights off, no result pending, ticks_per_step back to 5.
`default_nettype none

module status_led_blink_sequencer
  import slbs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Tick input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        is_initialising_i,
  input  wire logic        is_armed_i,
  input  wire logic [1:0]  gps_state_i,
  input  wire logic        battery_alarm_i,
  input  wire logic        radio_alarm_i,
  input  wire logic        ground_link_alarm_i,
  // Light output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             arm_light_o,
  output logic             gps_light_o,
  output logic             motor_light_a_o,
  output logic             motor_light_b_o,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [3:0] tps_q;
  logic [3:0] prescale_q, prescale_d;
  logic [3:0] step_q, step_d;
  logic       flash_active_q, flash_active_d;
  logic [3:0] flash_step_q, flash_step_d;
  light_t     light_q, light_d;
  logic       out_valid_q;

  logic       accept;
  logic       cfg_wr;
  logic       reg_sel;
  logic [3:0] ratio;
  logic [3:0] pre_inc;
  logic [3:0] step_inc;
  logic [3:0] flash_inc;
  logic       pass;
  logic       alarm;
  logic       arm_on;
  logic       flash_on;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_TICKS_PER_STEP[0]);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? {28'd0, tps_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TICKS_PER_STEP_RESET;
    end else if (cfg_wr) begin
      tps_q <= pwdata[3:0];
    end
  end

  // Handshake: the light register doubles as the output register
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Prescaler
  assign ratio   = (tps_q == 4'd0) ? 4'd1 : tps_q;
  assign pre_inc = prescale_q + 4'd1;
  assign pass    = (pre_inc >= ratio);

  // Next-state logic for one tick
  always_comb begin
    prescale_d     = pass ? 4'd0 : pre_inc;
    step_d         = step_q;
    flash_active_d = flash_active_q;
    flash_step_d   = flash_step_q;
    light_d        = light_q;
    alarm          = battery_alarm_i || radio_alarm_i || ground_link_alarm_i;
    step_inc       = step_q + 4'd1;
    flash_inc      = flash_step_q + 4'd1;
    arm_on         = 1'b0;
    flash_on       = 1'b0;

    if (pass) begin
      // Advance the pattern step and wrap
      step_d = (step_inc >= 4'(STEPS_PER_CYCLE)) ? 4'd0 : step_inc;

      if (is_initialising_i) begin
        // Alternate arm and GPS, leave the motor lights alone
        light_d.arm = ~step_d[0];
        light_d.gps = step_d[0];
      end else begin
        arm_on      = is_armed_i ? 1'b1 : blink_on(step_d);
        light_d.arm = arm_on;

        case (gps_state_i)
          GPS_NONE:   light_d.gps = 1'b0;
          GPS_LOCKED: light_d.gps = 1'b1;
          default:    light_d.gps = blink_on(step_d);
        endcase

        if (flash_active_q) begin
          // Advance the flash, drop it at the end
          if (flash_inc >= 4'(FLASH_LENGTH)) begin
            flash_on       = 1'b0;
            flash_active_d = 1'b0;
            flash_step_d   = 4'd0;
          end else begin
            flash_on     = flash_inc[0];
            flash_step_d = flash_inc;
          end
          light_d.motor_a = flash_on;
          light_d.motor_b = flash_on;
        end else if (alarm) begin
          // Start a flash, hold the motor lights this step
          flash_active_d = 1'b1;
          flash_step_d   = 4'd0;
        end else begin
          light_d.motor_a = arm_on;
          light_d.motor_b = arm_on;
        end
      end
    end
  end

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q     <= 4'd0;
      step_q         <= 4'd0;
      flash_active_q <= 1'b0;
      flash_step_q   <= 4'd0;
      light_q        <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        prescale_q     <= prescale_d;
        step_q         <= step_d;
        flash_active_q <= flash_active_d;
        flash_step_q   <= flash_step_d;
        light_q        <= light_d;
        out_valid_q    <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign arm_light_o     = light_q.arm;
  assign gps_light_o     = light_q.gps;
  assign motor_light_a_o = light_q.motor_a;
  assign motor_light_b_o = light_q.motor_b;

`ifndef NO_ASSERTIONS
  // Step counter stays inside the cycle
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < 4'(STEPS_PER_CYCLE))
    else $error("step counter out of range");

  // Flash counter is idle at zero and never reaches its length
  a_flash_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flash_active_q |-> flash_step_q == 4'd0)
    else $error("flash step nonzero while no flash runs");

  a_flash_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flash_step_q < 4'(FLASH_LENGTH))
    else $error("flash step out of range");

  // Every accepted tick yields a pending result
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted tick produced no result");

  // A stalled result keeps the state frozen
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(light_q) && $stable(step_q))
    else $error("state changed while result stalled");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_status_led_blink_sequencer.sv
// Self-checking testbench for the status light blink sequencer.
`timescale 1ns / 100ps

module tb_status_led_blink_sequencer;
  import slbs_pkg::*;

  // GPS states between none and locked: attached, still searching
  localparam logic [1:0] GPS_SEARCH_1 = 2'd1;
  localparam logic [1:0] GPS_SEARCH_2 = 2'd2;
  localparam logic [2:0] TICKS_ADDR   = 3'(REG_TICKS_PER_STEP * 4);
  localparam int         HOLD_CYCLES  = 300;
  localparam int         PHASE_TICKS  = 150;

  // One base tick with its status flags
  typedef struct packed {
    logic       init;
    logic       armed;
    logic [1:0] gps;
    logic       batt;
    logic       radio;
    logic       ground;
  } tick_t;

  // One directed row: optional ratio write, the tick, and a typed-in result
  typedef struct packed {
    bit         set_cfg;
    logic [3:0] ratio;
    tick_t      tick;
    bit         typed;
    light_t     lights;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  tick_t       in_tick = '0;
  bit          in_typed = 1'b0;
  light_t      in_typed_lights = '0;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_stall;
  logic        out_valid;
  logic        arm_light, gps_light, motor_a, motor_b;

  // Shared control of idling and receiver hold-off
  logic        quiet = 1'b0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  // Predicted block state
  logic [3:0]  ratio_cfg = TICKS_PER_STEP_RESET;
  logic [3:0]  pre_cnt = '0;
  logic [3:0]  step_cnt = '0;
  logic        flash_on = 1'b0;
  logic [3:0]  flash_cnt = '0;
  light_t      lights_now = '0;

  light_t      lights_due[$];
  dir_row_t    dir_rows[$];

  int          fail_cnt = 0;
  int          mismatch_cnt = 0;
  int          results_checked = 0;
  int          ticks_sent = 0;
  int          cfg_writes = 0;
  int          flashes_started = 0;
  int          stall_cycles = 0;

  status_led_blink_sequencer dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .is_initialising_i   (in_tick.init),
    .is_armed_i          (in_tick.armed),
    .gps_state_i         (in_tick.gps),
    .battery_alarm_i     (in_tick.batt),
    .radio_alarm_i       (in_tick.radio),
    .ground_link_alarm_i (in_tick.ground),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .arm_light_o         (arm_light),
    .gps_light_o         (gps_light),
    .motor_light_a_o     (motor_a),
    .motor_light_b_o     (motor_b),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Toggle the clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stop with a failure report after a timeout
  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

  // On-off pattern over the ten steps of a cycle
  function automatic logic blink_phase(input logic [3:0] s);
    blink_phase = (s inside {4'd3, 4'd4, 4'd8, 4'd9});
  endfunction

  // Advance the predicted state by one accepted tick, return the lights after it
  function automatic light_t predict_lights(input tick_t t);
    logic [3:0] ratio;
    logic       arm_on;
    logic       pulse;
    ratio   = (ratio_cfg == 4'd0) ? 4'd1 : ratio_cfg;
    pre_cnt = pre_cnt + 4'd1;
    if (pre_cnt >= ratio) begin
      pre_cnt  = '0;
      step_cnt = step_cnt + 4'd1;
      if (step_cnt >= 4'(STEPS_PER_CYCLE)) step_cnt = '0;
      if (t.init) begin
        // Alternate arm and GPS, leave the motors and the flash alone
        lights_now.arm = !step_cnt[0];
        lights_now.gps = step_cnt[0];
      end else begin
        arm_on = t.armed | blink_phase(step_cnt);
        lights_now.arm = arm_on;
        case (t.gps)
          GPS_NONE:   lights_now.gps = 1'b0;
          GPS_LOCKED: lights_now.gps = 1'b1;
          default:    lights_now.gps = blink_phase(step_cnt);
        endcase
        if (flash_on) begin
          flash_cnt = flash_cnt + 4'd1;
          if (flash_cnt >= 4'(FLASH_LENGTH)) begin
            pulse     = 1'b0;
            flash_on  = 1'b0;
            flash_cnt = '0;
          end else begin
            pulse = flash_cnt[0];
          end
          lights_now.motor_a = pulse;
          lights_now.motor_b = pulse;
        end else if (t.batt | t.radio | t.ground) begin
          // Start the flash, motors hold on this step
          flash_on  = 1'b1;
          flash_cnt = '0;
          flashes_started++;
        end else begin
          lights_now.motor_a = arm_on;
          lights_now.motor_b = arm_on;
        end
      end
    end
    return lights_now;
  endfunction

  function automatic tick_t status(input logic init, input logic armed, input logic [1:0] gps,
                                   input logic batt, input logic radio, input logic ground);
    tick_t t;
    t.init   = init;
    t.armed  = armed;
    t.gps    = gps;
    t.batt   = batt;
    t.radio  = radio;
    t.ground = ground;
    return t;
  endfunction

  function automatic void add_row(input bit set_cfg, input logic [3:0] ratio, input tick_t t,
                                  input bit typed, input light_t lt);
    dir_row_t r;
    r.set_cfg = set_cfg;
    r.ratio   = ratio;
    r.tick    = t;
    r.typed   = typed;
    r.lights  = lt;
    dir_rows.push_back(r);
  endfunction

  // Mostly plausible flight status, with some fully random noise
  function automatic tick_t random_status();
    tick_t t;
    if ($urandom_range(0, 99) < 15) begin
      t = 7'($urandom);
    end else begin
      t.init   = ($urandom_range(0, 99) < 8);
      t.armed  = 1'($urandom_range(0, 1));
      t.gps    = 2'($urandom_range(0, 3));
      t.batt   = ($urandom_range(0, 99) < 6);
      t.radio  = ($urandom_range(0, 99) < 6);
      t.ground = ($urandom_range(0, 99) < 6);
    end
    return t;
  endfunction

  // Drive the receiver stall: long hold-offs on request, else random idling
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 14);
    end
  end

  // Check each light result against the oldest expectation, then queue new ones
  always @(posedge clk) begin
    light_t got;
    light_t want;
    if (rst_n) begin
      if (in_valid && in_stall) stall_cycles++;
      if (out_valid && !out_stall) begin
        got.arm     = arm_light;
        got.gps     = gps_light;
        got.motor_a = motor_a;
        got.motor_b = motor_b;
        if (lights_due.size() == 0) begin
          fail_cnt++;
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("light result with no tick pending: %b", got);
        end else begin
          want = lights_due.pop_front();
          results_checked++;
          if (got !== want) begin
            fail_cnt++;
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("light result %0d (expected/actual): arm %b/%b gps %b/%b motor_a %b/%b motor_b %b/%b",
                       results_checked, want.arm, got.arm, want.gps, got.gps,
                       want.motor_a, got.motor_a, want.motor_b, got.motor_b);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = predict_lights(in_tick);
        lights_due.push_back(in_typed ? in_typed_lights : want);
        ticks_sent++;
      end
    end
  end

  // One APB transfer, setup then access, then back to idle
  task automatic apb_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= TICKS_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drain all pending results, then write and read back the divide ratio
  task automatic set_ratio(input logic [3:0] r);
    logic [31:0] rd;
    in_valid <= 1'b0;
    // Let the checker queue the last accepted tick before draining
    @(posedge clk);
    while (lights_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    apb_access(1'b1, {28'd0, r}, rd);
    ratio_cfg = r;
    cfg_writes++;
    apb_access(1'b0, '0, rd);
    if (rd !== {28'd0, r}) begin
      fail_cnt++;
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("ticks_per_step readback: expected %0d, got %h", r, rd);
    end
  endtask

  // Offer one tick, with an occasional idle gap carrying junk payload
  task automatic send_tick(input tick_t t, input bit typed, input light_t lt);
    int gap;
    if (!quiet && $urandom_range(0, 99) < 6) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      in_tick  <= 7'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_tick         <= t;
    in_typed        <= typed;
    in_typed_lights <= lt;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    logic [3:0] phase_ratio[8];

    // Reset value gives four held ticks, then an odd initialising step
    for (int k = 0; k < 4; k++) add_row(1'b0, '0, status(0, 0, GPS_NONE, 0, 0, 0), 1'b1, 4'b0000);
    add_row(1'b0, '0, status(1, 0, GPS_NONE, 0, 0, 0), 1'b1, 4'b0010);
    // Every tick passed: arm, GPS states, failsafe flash through its end
    add_row(1'b1, 4'd1, status(0, 1, GPS_LOCKED, 0, 0, 0), 1'b0, '0);
    add_row(1'b0, '0, status(0, 0, GPS_SEARCH_1, 0, 0, 0), 1'b0, '0);
    add_row(1'b0, '0, status(0, 0, GPS_SEARCH_2, 0, 0, 0), 1'b0, '0);
    add_row(1'b0, '0, status(0, 0, GPS_NONE, 1, 0, 0), 1'b0, '0);
    add_row(1'b0, '0, status(0, 1, GPS_LOCKED, 0, 1, 0), 1'b0, '0);
    for (int k = 0; k < 8; k++)
      add_row(1'b0, '0, status(0, k[0], 2'(k), k == 2, k == 5, k == 7), 1'b0, '0);
    add_row(1'b0, '0, status(0, 0, GPS_NONE, 0, 0, 0), 1'b0, '0);
    add_row(1'b0, '0, status(0, 0, GPS_SEARCH_1, 0, 1, 0), 1'b0, '0);
    // Zero ratio acts as one; initialising during a flash; slowest ratio
    add_row(1'b1, 4'd0, status(1, 1, GPS_LOCKED, 1, 1, 1), 1'b0, '0);
    add_row(1'b0, '0, status(0, 0, GPS_NONE, 0, 0, 1), 1'b0, '0);
    add_row(1'b1, 4'd15, status(0, 0, GPS_NONE, 0, 0, 0), 1'b0, '0);
    add_row(1'b0, '0, status(1, 1, GPS_LOCKED, 1, 1, 1), 1'b0, '0);

    phase_ratio = '{4'd1, 4'd0, 4'd15, 4'd2, TICKS_PER_STEP_RESET,
                    4'($urandom_range(1, 14)), 4'($urandom_range(1, 14)), 4'd3};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cfg) set_ratio(dir_rows[i].ratio);
      send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].lights);
    end

    // Random phases, one divide ratio each
    for (int p = 0; p < 8; p++) begin
      set_ratio(phase_ratio[p]);
      if (p == 1) hold_requests <= hold_requests + 1;
      if (p == 3) quiet <= 1'b1;
      if (p == 4) quiet <= 1'b0;
      for (int k = 0; k < PHASE_TICKS; k++) send_tick(random_status(), 1'b0, '0);
    end

    // Drain and let any stray result show up
    in_valid <= 1'b0;
    @(posedge clk);
    while (lights_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (lights_due.size() != 0) fail_cnt++;

    $display("Ran %0d ticks, checked %0d light results over %0d ratio writes",
             ticks_sent, results_checked, cfg_writes);
    $display("Saw %0d failsafe flashes and %0d cycles of input backpressure",
             flashes_started, stall_cycles);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
